@@ rtl/running_mean_variance_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Running mean and variance unit: assertion macros
// Shared property forms for the checker; clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH

// Same-cycle implication
`define RMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance: shared package
// Field widths, internal arithmetic widths, types and the sequencer states.
// ----------------------------------------------------------------------------
package rmv_pkg;

  // Lanes per sample vector (one port per element)
  localparam int LANES  = 3;

  // Field widths
  localparam int SMP_W  = 16;   // signed sample
  localparam int FRAC_W = 16;   // fractional bits of the means
  localparam int MEAN_W = 32;   // signed Q16.16 mean
  localparam int SQM_W  = 48;   // unsigned Q32.16 mean of squares
  localparam int VAR_W  = 46;   // unsigned Q30.16 variance
  localparam int CNT_W  = 32;   // saturating sample count

  // Divider widths
  localparam int NUM_W  = SQM_W + 1;          // signed difference
  localparam int MAG_W  = SQM_W;              // difference magnitude
  localparam int DEN_W  = CNT_W + 1;          // count + 1
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  // Squarer step counter
  localparam int SQR_CNT_W = $clog2(MEAN_W + 1);

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [MEAN_W-1:0] mean_t;
  typedef logic [SQM_W-1:0]         sqm_t;
  typedef logic [VAR_W-1:0]         var_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [DEN_W-1:0]         den_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DLOAD,
    ST_DIV,
    ST_UPD,
    ST_SLOAD,
    ST_SQR,
    ST_DONE
  } state_e;

  // Sequencer controls to the datapath
  typedef struct packed {
    logic in_ready;
    logic prep_en;
    logic div_start;
    logic upd_en;
    logic sqr_start;
    logic out_load;
  } seq_ctl_t;

endpackage

@@ rtl/rmv_div.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance: serial divider
// Signed dividend by unsigned divisor, one quotient bit per cycle (restoring),
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rmv_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  rmv_pkg::num_t num_i,
  input  rmv_pkg::den_t den_i,
  output logic         busy_o,
  output rmv_pkg::num_t quo_o
);

  logic [rmv_pkg::MAG_W-1:0]     dvd_q, dvd_d;
  logic [rmv_pkg::DEN_W-1:0]     rem_q, rem_d;
  rmv_pkg::den_t                 den_q, den_d;
  logic                          neg_q, neg_d;
  logic [rmv_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic [rmv_pkg::NUM_W-1:0] num_mag;
  logic [rmv_pkg::DEN_W:0]   trial;
  logic [rmv_pkg::DEN_W:0]   trial_sub;
  logic [rmv_pkg::NUM_W-1:0] quo_mag;

  // Step logic: shift one dividend bit into the partial remainder
  always_comb begin
    num_mag   = num_i[rmv_pkg::NUM_W-1] ? (~num_i + rmv_pkg::NUM_W'(1)) : num_i;
    trial     = {rem_q, dvd_q[rmv_pkg::MAG_W-1]};
    trial_sub = trial - {1'b0, den_q};

    dvd_d = dvd_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;

    if (start_i) begin
      dvd_d = num_mag[rmv_pkg::MAG_W-1:0];
      rem_d = '0;
      den_d = den_i;
      neg_d = num_i[rmv_pkg::NUM_W-1];
      cnt_d = rmv_pkg::DIV_CNT_W'(rmv_pkg::MAG_W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial_sub[rmv_pkg::DEN_W-1:0];
        dvd_d = {dvd_q[rmv_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_d = trial[rmv_pkg::DEN_W-1:0];
        dvd_d = {dvd_q[rmv_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - rmv_pkg::DIV_CNT_W'(1);
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Reapply the sign to the quotient magnitude
  assign quo_mag = {1'b0, dvd_q};
  assign quo_o   = neg_q ? (~quo_mag + rmv_pkg::NUM_W'(1)) : quo_mag;
  assign busy_o  = (cnt_q != '0);

endmodule

@@ rtl/rmv_sqr.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance: serial squarer and variance stage
// Squares the mean magnitude by shift-and-add, one multiplier bit per cycle,
// then forms mean of squares minus squared mean, clamped to the output range.
// ----------------------------------------------------------------------------
module rmv_sqr (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rmv_pkg::mean_t mean_i,
  input  rmv_pkg::sqm_t  sqm_i,
  output logic          busy_o,
  output rmv_pkg::var_t  var_o
);

  localparam int PROD_W = 2 * rmv_pkg::MEAN_W;

  logic [PROD_W-1:0]             prod_q, prod_d;
  logic [rmv_pkg::MEAN_W-1:0]    mcand_q, mcand_d;
  rmv_pkg::sqm_t                 sqm_q, sqm_d;
  logic [rmv_pkg::SQR_CNT_W-1:0] cnt_q, cnt_d;

  logic [rmv_pkg::MEAN_W-1:0] mag;
  logic [rmv_pkg::MEAN_W:0]   hi_sum;
  rmv_pkg::sqm_t              msq;
  rmv_pkg::sqm_t              vdiff;

  // Shift-and-add step, multiplier bits consumed LSB first
  always_comb begin
    mag    = mean_i[rmv_pkg::MEAN_W-1] ? (~mean_i + rmv_pkg::MEAN_W'(1)) : mean_i;
    hi_sum = {1'b0, prod_q[PROD_W-1:rmv_pkg::MEAN_W]}
           + (prod_q[0] ? {1'b0, mcand_q} : '0);

    prod_d  = prod_q;
    mcand_d = mcand_q;
    sqm_d   = sqm_q;
    cnt_d   = cnt_q;

    if (start_i) begin
      prod_d  = {{rmv_pkg::MEAN_W{1'b0}}, mag};
      mcand_d = mag;
      sqm_d   = sqm_i;
      cnt_d   = rmv_pkg::SQR_CNT_W'(rmv_pkg::MEAN_W);
    end else if (cnt_q != '0) begin
      prod_d = {hi_sum, prod_q[rmv_pkg::MEAN_W-1:1]};
      cnt_d  = cnt_q - rmv_pkg::SQR_CNT_W'(1);
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Product and operand registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
    sqm_q   <= sqm_d;
  end

  // Variance: clamp below at zero and above at the field maximum
  always_comb begin
    msq   = prod_q[PROD_W-1:rmv_pkg::FRAC_W];
    vdiff = sqm_q - msq;
    if (sqm_q <= msq) begin
      var_o = '0;
    end else if (vdiff[rmv_pkg::SQM_W-1:rmv_pkg::VAR_W] != '0) begin
      var_o = '1;
    end else begin
      var_o = vdiff[rmv_pkg::VAR_W-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);

endmodule

@@ rtl/running_mean_variance_unit.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance unit
// Per-lane running mean and mean of squares over a stream of sample vectors,
// with variances and a saturating sample count returned for every item.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+-----------------------------------
//   input   | in_valid_i / in_ready_o    | sample_0_i .. sample_2_i
//   output  | out_valid_o / out_ready_i  | mean_*_o, variance_*_o,
//           |                            | sample_count_o
//
// Per item the sequencer takes the input, forms the differences, runs the
// divide state (48-bit quotient magnitudes, one bit per cycle, all lanes in
// parallel, left when the dividers finish), updates the running state, runs
// the square state (32 multiplier bits) and then loads the output register.
// One item is in work at a time; the next is taken while a result still
// waits in the output register. A stalled output holds the sequencer in its
// final state until the register frees. Reset clears the means, squares and
// count to zero.
// ----------------------------------------------------------------------------
module running_mean_variance_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          sample_0_i,
  input  logic signed [15:0]          sample_1_i,
  input  logic signed [15:0]          sample_2_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          mean_0_o,
  output logic signed [31:0]          mean_1_o,
  output logic signed [31:0]          mean_2_o,
  output logic [45:0]                 variance_0_o,
  output logic [45:0]                 variance_1_o,
  output logic [45:0]                 variance_2_o,
  output logic [31:0]                 sample_count_o
);

  localparam int L = rmv_pkg::LANES;
  localparam int X2_W = 2 * rmv_pkg::SMP_W - 1;

  rmv_pkg::state_e  state_q, state_d;
  rmv_pkg::seq_ctl_t ctl;

  rmv_pkg::smp_t  smp_in [L];
  rmv_pkg::smp_t  smp_q  [L];
  logic [X2_W-1:0] x2_q  [L];
  rmv_pkg::num_t  nmean_q [L];
  rmv_pkg::num_t  nsq_q   [L];

  rmv_pkg::mean_t mean_q [L];
  rmv_pkg::sqm_t  sqm_q  [L];
  rmv_pkg::cnt_t  cnt_q;

  rmv_pkg::num_t  qmean [L];
  rmv_pkg::num_t  qsq   [L];
  logic [L-1:0]   div_busy_m, div_busy_s, sqr_busy;
  rmv_pkg::var_t  var_w [L];
  rmv_pkg::den_t  den;

  rmv_pkg::mean_t mean_out_q [L];
  rmv_pkg::var_t  var_out_q  [L];
  rmv_pkg::cnt_t  cnt_out_q;
  logic           out_valid_q;
  logic           out_free;

  assign smp_in[0] = sample_0_i;
  assign smp_in[1] = sample_1_i;
  assign smp_in[2] = sample_2_i;

  assign den      = rmv_pkg::DEN_W'(cnt_q) + rmv_pkg::DEN_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state and controls
  always_comb begin
    state_d = state_q;
    ctl     = '0;
    case (state_q)
      rmv_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = rmv_pkg::ST_PREP;
        end
      end
      rmv_pkg::ST_PREP: begin
        ctl.prep_en = 1'b1;
        state_d     = rmv_pkg::ST_DLOAD;
      end
      rmv_pkg::ST_DLOAD: begin
        ctl.div_start = 1'b1;
        state_d       = rmv_pkg::ST_DIV;
      end
      rmv_pkg::ST_DIV: begin
        if (div_busy_m == '0 && div_busy_s == '0) begin
          state_d = rmv_pkg::ST_UPD;
        end
      end
      rmv_pkg::ST_UPD: begin
        ctl.upd_en = 1'b1;
        state_d    = rmv_pkg::ST_SLOAD;
      end
      rmv_pkg::ST_SLOAD: begin
        ctl.sqr_start = 1'b1;
        state_d       = rmv_pkg::ST_SQR;
      end
      rmv_pkg::ST_SQR: begin
        if (sqr_busy == '0) begin
          state_d = rmv_pkg::ST_DONE;
        end
      end
      rmv_pkg::ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_d      = rmv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmv_pkg::ST_IDLE;
      end
    endcase
  end

  // Input capture; the sample square is formed on the way in
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      if (ctl.in_ready && in_valid_i) begin
        smp_q[i] <= smp_in[i];
        x2_q[i]  <= X2_W'(rmv_pkg::MEAN_W'(smp_in[i]) * rmv_pkg::MEAN_W'(smp_in[i]));
      end
    end
  end

  // Differences to the stored means, ready for the dividers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      if (ctl.prep_en) begin
        nmean_q[i] <= rmv_pkg::NUM_W'(signed'({smp_q[i], {rmv_pkg::FRAC_W{1'b0}}}))
                    - rmv_pkg::NUM_W'(mean_q[i]);
        nsq_q[i]   <= rmv_pkg::NUM_W'({x2_q[i], {rmv_pkg::FRAC_W{1'b0}}})
                    - rmv_pkg::NUM_W'(sqm_q[i]);
      end
    end
  end

  // Running state: means, mean of squares, saturating count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < L; i++) begin
        mean_q[i] <= '0;
        sqm_q[i]  <= '0;
      end
      cnt_q <= '0;
    end else if (ctl.upd_en) begin
      for (int i = 0; i < L; i++) begin
        mean_q[i] <= mean_q[i] + qmean[i][rmv_pkg::MEAN_W-1:0];
        sqm_q[i]  <= sqm_q[i] + qsq[i][rmv_pkg::SQM_W-1:0];
      end
      if (cnt_q != '1) begin
        cnt_q <= cnt_q + rmv_pkg::CNT_W'(1);
      end
    end
  end

  // Per-lane serial units
  for (genvar g = 0; g < L; g++) begin : g_lane
    rmv_div u_div_mean (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ctl.div_start),
      .num_i   (nmean_q[g]),
      .den_i   (den),
      .busy_o  (div_busy_m[g]),
      .quo_o   (qmean[g])
    );

    rmv_div u_div_sq (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ctl.div_start),
      .num_i   (nsq_q[g]),
      .den_i   (den),
      .busy_o  (div_busy_s[g]),
      .quo_o   (qsq[g])
    );

    rmv_sqr u_sqr (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ctl.sqr_start),
      .mean_i  (mean_q[g]),
      .sqm_i   (sqm_q[g]),
      .busy_o  (sqr_busy[g]),
      .var_o   (var_w[g])
    );
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      for (int i = 0; i < L; i++) begin
        mean_out_q[i] <= mean_q[i];
        var_out_q[i]  <= var_w[i];
      end
      cnt_out_q <= cnt_q;
    end
  end

  assign in_ready_o     = ctl.in_ready;
  assign out_valid_o    = out_valid_q;
  assign mean_0_o       = mean_out_q[0];
  assign mean_1_o       = mean_out_q[1];
  assign mean_2_o       = mean_out_q[2];
  assign variance_0_o   = var_out_q[0];
  assign variance_1_o   = var_out_q[1];
  assign variance_2_o   = var_out_q[2];
  assign sample_count_o = cnt_out_q;

endmodule

@@ rtl/rmv_checker.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance: port checker
// Watches the top-level ports for output holding, busy after a transfer,
// a live count on every result and the first-sample identities.
// ----------------------------------------------------------------------------
`include "running_mean_variance_unit_assert.svh"

module rmv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [15:0] sample_0_i,
  input logic signed [15:0] sample_1_i,
  input logic signed [15:0] sample_2_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] mean_0_o,
  input logic signed [31:0] mean_1_o,
  input logic signed [31:0] mean_2_o,
  input logic [45:0]        variance_0_o,
  input logic [45:0]        variance_1_o,
  input logic [45:0]        variance_2_o,
  input logic [31:0]        sample_count_o
);

  // A waiting result keeps its lane 0 mean and variance and its sample count
  `RMV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(mean_0_o) && $stable(variance_0_o) && $stable(sample_count_o),
    "result changed while stalled")

  // One item in work at a time: no transfer in the cycle after one
  `RMV_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o,
    "input taken while an item is in work")

  // Every result counts at least the item that made it
  `RMV_ASSERT_NOW(a_count_live, out_valid_o, sample_count_o != 32'd0,
    "result with zero sample count")

  // First sample: integer means and no spread
  `RMV_ASSERT_NOW(a_first_sample, out_valid_o && sample_count_o == 32'd1,
    mean_0_o[15:0] == 16'd0 && mean_1_o[15:0] == 16'd0 && mean_2_o[15:0] == 16'd0
      && variance_0_o == 46'd0 && variance_1_o == 46'd0 && variance_2_o == 46'd0,
    "first sample gave a fractional mean or a non-zero variance")

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (.*);
